/* design/bin_peak_region_segmenter_unit_assert.svh */
// assertion macros for the peak region segmenter
`ifndef BIN_PEAK_REGION_SEGMENTER_UNIT_ASSERT_SVH
`define BIN_PEAK_REGION_SEGMENTER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BPRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bprs check failed");

// antecedent implies consequent in the next cycle
`define BPRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bprs check failed");

`endif

/* design/bprs_pkg.sv */
package bprs_pkg;

   localparam int BIN_BITS   = 24;
   localparam int VALUE_BITS = 32;
   localparam int CHROM_BITS = 8;
   localparam int GAP_BITS   = 9;
   localparam int MAXGAP_BITS = 8;

   localparam int REQ_FIELD_BITS = BIN_BITS + 4 * VALUE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = CHROM_BITS + 3 * BIN_BITS + 4 * VALUE_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = VALUE_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHROMOSOME         = 4'd0,
      CSR_HAS_CONTROL        = 4'd1,
      CSR_RATIO_ONLY_MODE    = 4'd2,
      CSR_RATIO_THRESHOLD    = 4'd3,
      CSR_TAG_THRESHOLD      = 4'd4,
      CSR_P_ENRICH_THRESHOLD = 4'd5,
      CSR_P_INTER_THRESHOLD  = 4'd6,
      CSR_MAX_GAP            = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [CHROM_BITS-1:0]  chromosome;
      logic                   has_control;
      logic                   ratio_only_mode;
      logic [VALUE_BITS-1:0]  ratio_threshold;
      logic [VALUE_BITS-1:0]  tag_threshold;
      logic [VALUE_BITS-1:0]  p_enrich_threshold;
      logic [VALUE_BITS-1:0]  p_inter_threshold;
      logic [MAXGAP_BITS-1:0] max_gap;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      chromosome:         '0,
      has_control:        1'b1,
      ratio_only_mode:    1'b0,
      ratio_threshold:    VALUE_BITS'(131072),
      tag_threshold:      '0,
      p_enrich_threshold: VALUE_BITS'(262144),
      p_inter_threshold:  VALUE_BITS'(262144),
      max_gap:            MAXGAP_BITS'(1)
   };

   typedef struct packed {
      logic [VALUE_BITS-1:0] score_enrich;
      logic [VALUE_BITS-1:0] score_inter;
      logic [VALUE_BITS-1:0] enrich_ratio;
      logic [VALUE_BITS-1:0] tag_level;
      logic [BIN_BITS-1:0]   bin_index;
      logic                  excluded;
      logic                  final_bin;
   } bin_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] max_enrich;
      logic [VALUE_BITS-1:0] max_inter;
      logic [VALUE_BITS-1:0] max_ratio;
      logic [VALUE_BITS-1:0] max_tag;
      logic [BIN_BITS-1:0]   summit;
      logic [BIN_BITS-1:0]   end_bin;
      logic [BIN_BITS-1:0]   start;
      logic [CHROM_BITS-1:0] chromosome;
   } peak_type;

   typedef struct packed {
      logic peak_open;
      logic emit;
   } track_status_type;

endpackage

/* design/bprs_tracker.sv */
module bprs_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  bprs_pkg::bin_type          item,
   input  bprs_pkg::cfg_type          cfg,
   output bprs_pkg::peak_type         peak,
   output bprs_pkg::track_status_type status
);
   import bprs_pkg::*;

   logic [GAP_BITS-1:0]   gap_ff, gap_in;
   logic [CHROM_BITS-1:0] chrom_ff, chrom_in;
   logic [BIN_BITS-1:0]   start_ff, start_in;
   logic [BIN_BITS-1:0]   summit_ff, summit_in;
   logic [VALUE_BITS-1:0] tag_ff, tag_in;
   logic [VALUE_BITS-1:0] ratio_ff, ratio_in;
   logic [VALUE_BITS-1:0] inter_ff, inter_in;
   logic [VALUE_BITS-1:0] enrich_ff, enrich_in;

   logic                  sig;
   logic                  emit;
   logic [BIN_BITS-1:0]   end_bin;
   logic                  ratio_up, inter_up, enrich_up;

   always_comb begin
      if (cfg.has_control) begin
         if (cfg.ratio_only_mode) begin
            sig = (item.enrich_ratio > cfg.ratio_threshold)
               && (item.tag_level > cfg.tag_threshold);
         end else begin
            sig = (item.score_enrich > cfg.p_enrich_threshold)
               && (item.score_inter > cfg.p_inter_threshold)
               && (item.enrich_ratio > cfg.ratio_threshold)
               && (item.tag_level > cfg.tag_threshold);
         end
      end else begin
         sig = (item.score_inter > cfg.p_inter_threshold)
            && (item.tag_level > cfg.tag_threshold);
      end
   end

   assign ratio_up  = ratio_ff < item.enrich_ratio;
   assign inter_up  = inter_ff < item.score_inter;
   assign enrich_up = enrich_ff < item.score_enrich;

   always_comb begin
      gap_in    = gap_ff;
      chrom_in  = chrom_ff;
      start_in  = start_ff;
      summit_in = summit_ff;
      tag_in    = tag_ff;
      ratio_in  = ratio_ff;
      inter_in  = inter_ff;
      enrich_in = enrich_ff;
      emit      = 1'b0;
      end_bin   = item.bin_index - BIN_BITS'(gap_ff);

      if (gap_ff == '0) begin
         if (!item.excluded && sig) begin
            chrom_in  = cfg.chromosome;
            start_in  = item.bin_index;
            summit_in = item.bin_index;
            tag_in    = item.tag_level;
            ratio_in  = item.enrich_ratio;
            inter_in  = item.score_inter;
            enrich_in = item.score_enrich;
            gap_in    = GAP_BITS'(1);
         end
      end else if (item.excluded) begin
         emit   = 1'b1;
         gap_in = '0;
      end else if (sig) begin
         if (tag_ff < item.tag_level) begin
            tag_in = item.tag_level;
         end
         if (ratio_up) begin
            ratio_in = item.enrich_ratio;
         end
         if (inter_up) begin
            inter_in = item.score_inter;
         end
         if (enrich_up) begin
            enrich_in = item.score_enrich;
         end
         // summit follows ratio, enrichment or internal score by mode
         if ((cfg.ratio_only_mode && ratio_up)
            || (!cfg.ratio_only_mode && !cfg.has_control && inter_up)
            || (!cfg.ratio_only_mode && cfg.has_control && enrich_up)) begin
            summit_in = item.bin_index;
         end
         gap_in = GAP_BITS'(1);
      end else if (gap_ff > GAP_BITS'(cfg.max_gap)) begin
         emit   = 1'b1;
         gap_in = '0;
      end else begin
         gap_in = gap_ff + GAP_BITS'(1);
      end

      // last bin closes whatever is still open
      if (item.final_bin && gap_in != '0) begin
         emit    = 1'b1;
         end_bin = item.bin_index + BIN_BITS'(1) - BIN_BITS'(gap_in);
         gap_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (step) begin
         gap_ff <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chrom_ff  <= '0;
         start_ff  <= '0;
         summit_ff <= '0;
         tag_ff    <= '0;
         ratio_ff  <= '0;
         inter_ff  <= '0;
         enrich_ff <= '0;
      end else if (step) begin
         chrom_ff  <= chrom_in;
         start_ff  <= start_in;
         summit_ff <= summit_in;
         tag_ff    <= tag_in;
         ratio_ff  <= ratio_in;
         inter_ff  <= inter_in;
         enrich_ff <= enrich_in;
      end
   end

   assign peak.chromosome = chrom_in;
   assign peak.start      = start_in;
   assign peak.end_bin    = end_bin;
   assign peak.summit     = summit_in;
   assign peak.max_tag    = tag_in;
   assign peak.max_ratio  = ratio_in;
   assign peak.max_inter  = inter_in;
   assign peak.max_enrich = enrich_in;

   assign status.peak_open = gap_ff != '0;
   assign status.emit      = emit;

endmodule

/* design/bin_peak_region_segmenter_unit.sv */
// Groups a stream of genome bins into peak regions, one bin per req beat. A bin is
// taken every cycle while results are taken; a closed peak reaches rsp through the
// input register, the combinational peak tracker update and the result register. At
// most one result follows each bin. The user must write thresholds, mode and chromosome
// through csr only while the stream is idle; the block itself does not enforce it.
`include "bin_peak_region_segmenter_unit_assert.svh"

module bin_peak_region_segmenter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bin_index, tag_level, enrich_ratio, score_inter, score_enrich
   input  logic [bprs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // excluded
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // peak_chromosome, peak_start, peak_end, peak_summit, peak_max_tag,
   // peak_max_ratio, peak_max_inter, peak_max_enrich
   output logic [bprs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bprs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bprs_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bprs_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             in_valid_ff, in_valid_in;
   bin_type          in_item_ff, in_item_in;
   logic             out_valid_ff, out_valid_in;
   peak_type         out_peak_ff, out_peak_in;
   peak_type         peak;
   track_status_type status;
   logic             advance;
   logic             fire;
   logic             close_excl;
   logic             close_final;
   logic             idle_step;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CHROMOSOME:         cfg_in.chromosome = csr_data[CHROM_BITS-1:0];
            CSR_HAS_CONTROL:        cfg_in.has_control = csr_data[0];
            CSR_RATIO_ONLY_MODE:    cfg_in.ratio_only_mode = csr_data[0];
            CSR_RATIO_THRESHOLD:    cfg_in.ratio_threshold = csr_data[VALUE_BITS-1:0];
            CSR_TAG_THRESHOLD:      cfg_in.tag_threshold = csr_data[VALUE_BITS-1:0];
            CSR_P_ENRICH_THRESHOLD: cfg_in.p_enrich_threshold = csr_data[VALUE_BITS-1:0];
            CSR_P_INTER_THRESHOLD:  cfg_in.p_inter_threshold = csr_data[VALUE_BITS-1:0];
            CSR_MAX_GAP:            cfg_in.max_gap = csr_data[MAXGAP_BITS-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in = in_item_ff;
      {in_item_in.score_enrich, in_item_in.score_inter, in_item_in.enrich_ratio,
       in_item_in.tag_level, in_item_in.bin_index} = req_tdata[REQ_FIELD_BITS-1:0];
      in_item_in.excluded  = req_tuser;
      in_item_in.final_bin = req_tlast;
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= in_item_in;
      end
   end

   bprs_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .peak   (peak),
      .status (status)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_peak_in  = out_peak_ff;
      if (advance) begin
         out_valid_in = fire && status.emit;
         out_peak_in  = peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_peak_ff <= out_peak_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_peak_ff.max_enrich, out_peak_ff.max_inter,
                        out_peak_ff.max_ratio, out_peak_ff.max_tag,
                        out_peak_ff.summit, out_peak_ff.end_bin,
                        out_peak_ff.start, out_peak_ff.chromosome};

   assign close_excl  = fire && in_item_ff.excluded && status.peak_open;
   assign close_final = fire && in_item_ff.final_bin;
   assign idle_step   = fire && !status.peak_open && !in_item_ff.final_bin;

   // an excluded bin inside a peak always closes it
   `BPRS_ASSERT_NEXT(a_excluded_closes, clock, reset, close_excl, out_valid_ff && !status.peak_open)
   // nothing stays open past the last bin
   `BPRS_ASSERT_NEXT(a_final_clears, clock, reset, close_final, !status.peak_open)
   // with no open peak only the last bin can emit
   `BPRS_ASSERT_NEXT(a_no_spurious, clock, reset, idle_step, !out_valid_ff)
   // a bin that emits a result is only stepped while the result register can advance
   `BPRS_ASSERT_SAME(a_emit_needs_step, clock, reset, status.emit && fire, advance)

endmodule

/* test/bin_peak_region_segmenter_unit_test.sv */
module bin_peak_region_segmenter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bprs_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT = 3000;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int BINS_PER_PHASE = 270;

   class peak_book;
      cfg_type regs;
      logic [GAP_BITS-1:0] gap_count;
      peak_type open_peak;
      peak_type pending_peaks[$];
      int fail_count;

      function new();
         regs = CFG_RESET;
         gap_count = '0;
         open_peak = '0;
         fail_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_CHROMOSOME:         regs.chromosome = value[CHROM_BITS-1:0];
            CSR_HAS_CONTROL:        regs.has_control = value[0];
            CSR_RATIO_ONLY_MODE:    regs.ratio_only_mode = value[0];
            CSR_RATIO_THRESHOLD:    regs.ratio_threshold = value;
            CSR_TAG_THRESHOLD:      regs.tag_threshold = value;
            CSR_P_ENRICH_THRESHOLD: regs.p_enrich_threshold = value;
            CSR_P_INTER_THRESHOLD:  regs.p_inter_threshold = value;
            CSR_MAX_GAP:            regs.max_gap = value[MAXGAP_BITS-1:0];
            default: ;
         endcase
      endfunction

      function bit passes(bin_type b);
         if (regs.has_control) begin
            if (regs.ratio_only_mode)
               return b.enrich_ratio > regs.ratio_threshold &&
                      b.tag_level > regs.tag_threshold;
            return b.score_enrich > regs.p_enrich_threshold &&
                   b.score_inter > regs.p_inter_threshold &&
                   b.enrich_ratio > regs.ratio_threshold &&
                   b.tag_level > regs.tag_threshold;
         end
         return b.score_inter > regs.p_inter_threshold && b.tag_level > regs.tag_threshold;
      endfunction

      function void close_peak(logic [BIN_BITS-1:0] end_bin);
         peak_type p;
         p = open_peak;
         p.end_bin = end_bin;
         pending_peaks.push_back(p);
         gap_count = '0;
      endfunction

      function void note_bin(bin_type b);
         bit sig;
         sig = passes(b);
         if (gap_count == 0) begin
            if (!b.excluded && sig) begin
               open_peak.chromosome = regs.chromosome;
               open_peak.start = b.bin_index;
               open_peak.summit = b.bin_index;
               open_peak.max_tag = b.tag_level;
               open_peak.max_ratio = b.enrich_ratio;
               open_peak.max_inter = b.score_inter;
               open_peak.max_enrich = b.score_enrich;
               gap_count = GAP_BITS'(1);
            end
         end else if (b.excluded) begin
            close_peak(b.bin_index - gap_count);
         end else if (sig) begin
            if (open_peak.max_tag < b.tag_level)
               open_peak.max_tag = b.tag_level;
            if (open_peak.max_ratio < b.enrich_ratio) begin
               open_peak.max_ratio = b.enrich_ratio;
               if (regs.ratio_only_mode)
                  open_peak.summit = b.bin_index;
            end
            if (open_peak.max_inter < b.score_inter) begin
               open_peak.max_inter = b.score_inter;
               if (!regs.ratio_only_mode && !regs.has_control)
                  open_peak.summit = b.bin_index;
            end
            if (open_peak.max_enrich < b.score_enrich) begin
               open_peak.max_enrich = b.score_enrich;
               if (!regs.ratio_only_mode && regs.has_control)
                  open_peak.summit = b.bin_index;
            end
            gap_count = GAP_BITS'(1);
         end else if (gap_count > regs.max_gap) begin
            close_peak(b.bin_index - gap_count);
         end else begin
            gap_count = gap_count + 1'b1;
         end
         if (b.final_bin && gap_count != 0)
            close_peak(b.bin_index + 1'b1 - gap_count);
      endfunction

      function void compare_field(string name, logic [VALUE_BITS-1:0] want,
                                  logic [VALUE_BITS-1:0] got);
         if (want !== got) begin
            $display("%0t peak %s: expected %h, got %h", $time, name, want, got);
            fail_count++;
         end
      endfunction

      function void check_peak(logic [RSP_DATA_BITS-1:0] data);
         peak_type want;
         peak_type got;
         got.chromosome = data[0 +: CHROM_BITS];
         got.start = data[8 +: BIN_BITS];
         got.end_bin = data[32 +: BIN_BITS];
         got.summit = data[56 +: BIN_BITS];
         got.max_tag = data[80 +: VALUE_BITS];
         got.max_ratio = data[112 +: VALUE_BITS];
         got.max_inter = data[144 +: VALUE_BITS];
         got.max_enrich = data[176 +: VALUE_BITS];
         if (pending_peaks.size() == 0) begin
            $display("%0t unexpected peak: expected none, got %h", $time, data);
            fail_count++;
            return;
         end
         want = pending_peaks.pop_front();
         compare_field("chromosome", VALUE_BITS'(want.chromosome),
                       VALUE_BITS'(got.chromosome));
         compare_field("start", VALUE_BITS'(want.start), VALUE_BITS'(got.start));
         compare_field("end", VALUE_BITS'(want.end_bin), VALUE_BITS'(got.end_bin));
         compare_field("summit", VALUE_BITS'(want.summit), VALUE_BITS'(got.summit));
         compare_field("max_tag", want.max_tag, got.max_tag);
         compare_field("max_ratio", want.max_ratio, got.max_ratio);
         compare_field("max_inter", want.max_inter, got.max_inter);
         compare_field("max_enrich", want.max_enrich, got.max_enrich);
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CHROMOSOME;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   peak_book book = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit squeeze_req = 1'b0;
   int squeeze_left = 0;
   int quiet_cycles = 0;

   bin_peak_region_segmenter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: check each beat, then decide the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_peak(rsp_tdata);
      if (squeeze_req) begin
         squeeze_req = 1'b0;
         squeeze_left = SQUEEZE_CYCLES;
      end
      if (squeeze_left > 0) begin
         squeeze_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic logic [VALUE_BITS-1:0] value_vs(logic [VALUE_BITS-1:0] thr, bit above);
      if ($urandom_range(7) == 0)
         return $urandom();
      if (above) begin
         if (thr == '1)
            return thr;
         if ($urandom_range(7) == 0)
            return thr + 1'b1;
         return $urandom_range(32'hFFFF_FFFF, thr + 1'b1);
      end
      if ($urandom_range(7) == 0)
         return thr;
      return $urandom_range(thr, 0);
   endfunction

   function automatic bin_type shaped_bin(logic [BIN_BITS-1:0] idx, bit sig);
      bin_type b;
      b.bin_index = idx;
      b.tag_level = value_vs(book.regs.tag_threshold, sig || $urandom_range(1));
      b.enrich_ratio = value_vs(book.regs.ratio_threshold, sig || $urandom_range(1));
      b.score_inter = value_vs(book.regs.p_inter_threshold, sig || $urandom_range(1));
      b.score_enrich = value_vs(book.regs.p_enrich_threshold, sig || $urandom_range(1));
      b.excluded = 1'b0;
      b.final_bin = 1'b0;
      return b;
   endfunction

   function automatic bin_type mk(logic [BIN_BITS-1:0] idx, logic [VALUE_BITS-1:0] tag,
                                  logic [VALUE_BITS-1:0] ratio, logic [VALUE_BITS-1:0] inter,
                                  logic [VALUE_BITS-1:0] enr, bit excl, bit fin);
      bin_type b;
      b.bin_index = idx;
      b.tag_level = tag;
      b.enrich_ratio = ratio;
      b.score_inter = inter;
      b.score_enrich = enr;
      b.excluded = excl;
      b.final_bin = fin;
      return b;
   endfunction

   task automatic send_bin(bin_type b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b.score_enrich, b.score_inter, b.enrich_ratio, b.tag_level, b.bin_index};
      req_tuser <= b.excluded;
      req_tlast <= b.final_bin;
      do
         @(posedge clock);
      while (!req_tready);
      book.note_bin(b);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      book.write_reg(idx, value);
   endtask

   task automatic program_regs(cfg_type c);
      write_csr(CSR_CHROMOSOME, CSR_DATA_BITS'(c.chromosome));
      write_csr(CSR_HAS_CONTROL, CSR_DATA_BITS'(c.has_control));
      write_csr(CSR_RATIO_ONLY_MODE, CSR_DATA_BITS'(c.ratio_only_mode));
      write_csr(CSR_RATIO_THRESHOLD, c.ratio_threshold);
      write_csr(CSR_TAG_THRESHOLD, c.tag_threshold);
      write_csr(CSR_P_ENRICH_THRESHOLD, c.p_enrich_threshold);
      write_csr(CSR_P_INTER_THRESHOLD, c.p_inter_threshold);
      write_csr(CSR_MAX_GAP, CSR_DATA_BITS'(c.max_gap));
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.pending_peaks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // runs of mostly consecutive bins with random content, some gaps near max_gap and noise
   task automatic run_bins(int count);
      int left;
      int quiet;
      int dens;
      logic [BIN_BITS-1:0] idx;
      bin_type b;
      bit sig;
      left = 0;
      quiet = 0;
      dens = 50;
      idx = '0;
      for (int n = 0; n < count; n++) begin
         if (left == 0) begin
            left = $urandom_range(60, 5);
            dens = $urandom_range(95, 20);
            idx = BIN_BITS'($urandom());
            quiet = 0;
         end
         if ($urandom_range(49) == 0) begin
            b = mk(BIN_BITS'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            if (quiet > 0) begin
               sig = 1'b0;
               quiet--;
            end else begin
               sig = ($urandom_range(99) < dens);
               if ($urandom_range(11) == 0)
                  quiet = int'(book.regs.max_gap) + int'($urandom_range(2)) - 1;
            end
            b = shaped_bin(idx, sig);
            b.excluded = ($urandom_range(29) == 0);
            b.final_bin = (left == 1 && quiet <= 0);
            if ($urandom_range(29) == 0)
               idx = idx + BIN_BITS'($urandom_range(3));
            else
               idx = idx + 1'b1;
            if (quiet <= 0)
               left--;
         end
         send_bin(b);
      end
   endtask

   initial begin
      cfg_type c;
      logic [VALUE_BITS-1:0] hi;
      hi = 32'h0004_0001;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: control present, all four tests, max_gap 1
      send_bin(mk(24'd0, '0, '0, '0, '0, 1'b0, 1'b0));
      send_bin(mk(24'd5, hi, hi, hi, hi, 1'b1, 1'b0));
      send_bin(mk(24'd10, hi, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd11, '1, '1, '1, '1, 1'b0, 1'b0));
      send_bin(mk(24'd12, '0, '0, '0, '0, 1'b0, 1'b0));
      send_bin(mk(24'd13, '0, '0, '0, '0, 1'b0, 1'b0));
      send_bin(mk(24'd20, hi, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd21, hi, hi, hi, hi, 1'b1, 1'b0));
      send_bin(mk(24'hFF_FFFF, hi, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd0, hi, hi, hi, 32'h0005_0000, 1'b0, 1'b1));
      send_bin(mk(24'd30, hi, hi, hi, hi, 1'b0, 1'b1));
      send_bin(mk(24'd40, hi, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd41, '0, hi, hi, hi, 1'b0, 1'b1));
      send_bin(mk(24'd50, hi, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd51, hi, '0, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd52, hi, hi, '0, hi, 1'b0, 1'b1));
      // strict compares at the thresholds
      send_bin(mk(24'd60, '0, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd61, hi, hi, hi, 32'd262144, 1'b0, 1'b0));
      send_bin(mk(24'd62, 32'd1, 32'd131073, 32'd262145, 32'd262145, 1'b0, 1'b0));
      send_bin(mk(24'd63, '0, '0, '0, '0, 1'b1, 1'b0));
      send_bin(mk(24'd70, 32'd5, hi, hi, 32'h0007_0000, 1'b0, 1'b0));
      send_bin(mk(24'd71, 32'd3, hi, hi, 32'h0008_0000, 1'b0, 1'b0));
      send_bin(mk(24'd72, 32'd9, hi, 32'h0009_0000, 32'h0006_0000, 1'b0, 1'b1));
      send_bin(mk(24'd80, hi, hi, hi, hi, 1'b0, 1'b0));
      send_bin(mk(24'd81, hi, hi, hi, hi, 1'b1, 1'b1));

      for (int phase = 1; phase <= 7; phase++) begin
         settle();
         c.chromosome = CHROM_BITS'($urandom());
         c.has_control = 1'($urandom_range(1));
         c.ratio_only_mode = 1'($urandom_range(1));
         c.ratio_threshold = $urandom_range(32'h0008_0000);
         c.tag_threshold = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0008_0000);
         c.p_enrich_threshold = $urandom_range(32'h0008_0000);
         c.p_inter_threshold = $urandom_range(32'h0008_0000);
         c.max_gap = MAXGAP_BITS'($urandom_range(6));
         case (phase)
            1: begin
               c.chromosome = 8'hFF;
               c.has_control = 1'b0;
               c.ratio_only_mode = 1'b0;
               c.ratio_threshold = '0;
               c.tag_threshold = '0;
               c.p_enrich_threshold = '0;
               c.p_inter_threshold = '0;
               c.max_gap = '0;
            end
            2: begin
               c.has_control = 1'b1;
               c.ratio_only_mode = 1'b1;
            end
            3: begin
               c.chromosome = '0;
               c.has_control = 1'b1;
               c.ratio_only_mode = 1'b0;
               c.ratio_threshold = 32'hFFFF_FFFE;
               c.tag_threshold = 32'hFFFF_FFFE;
               c.p_enrich_threshold = 32'hFFFF_FFFE;
               c.p_inter_threshold = 32'hFFFF_FFFE;
               c.max_gap = 8'hFF;
            end
            4: begin
               c.has_control = 1'b0;
               c.ratio_only_mode = 1'b1;
               c.max_gap = 8'hFF;
            end
            5: begin
               c.ratio_threshold = '1;
               c.tag_threshold = '1;
               c.p_enrich_threshold = '1;
               c.p_inter_threshold = '1;
            end
            default: ;
         endcase
         program_regs(c);
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
         endcase
         if (phase == 2)
            squeeze_req = 1'b1;
         run_bins((phase == 5) ? 60 : BINS_PER_PHASE);
      end

      settle();
      if (book.fail_count == 0 && book.pending_peaks.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
